/* hw/rtl/stl_pkg.sv */
// shared types, widths and lookup tables for the script token lexer
// no dependencies; used by the channel interfaces and the top level
package stl_pkg;

    localparam int POSITION_BITS_DEF   = 20;
    localparam int MAX_KEYWORD_LEN_DEF = 12;

    localparam int CH_W     = 8;
    localparam int KIND_W   = 5;
    localparam int LINE_W   = 20;
    localparam int START_W  = 20;
    localparam int LEN_W    = 21;
    localparam int KW_COUNT = 10;
    localparam int OP_COUNT = 15;
    localparam int OP_IDX_W = 4;

    localparam logic [LINE_W-1:0] FIRST_LINE_RESET = 20'd1;

    localparam logic [CH_W-1:0] CH_LF     = 8'h0a;
    localparam logic [CH_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CH_W-1:0] CH_UNDER  = 8'h5f;
    localparam logic [CH_W-1:0] CH_DOT    = 8'h2e;
    localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CH_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CH_W-1:0] CH_EQUAL  = 8'h3d;
    localparam logic [CH_W-1:0] CH_BANG   = 8'h21;

    localparam int KW_LEN [KW_COUNT] = '{3, 2, 4, 3, 3, 6, 8, 12, 10, 11};

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [LINE_W-1:0]  line;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
    } tok_t;

    typedef struct packed {
        logic                hit;
        logic [OP_IDX_W-1:0] idx;
    } op_hit_t;

    function automatic logic is_digit(input logic [CH_W-1:0] c);
        is_digit = c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [CH_W-1:0] c);
        is_alpha = c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
    endfunction

    function automatic logic is_space(input logic [CH_W-1:0] c);
        is_space = c inside {8'h20, [8'h09:8'h0d]};
    endfunction

    // keyword text, right justified: last character in the low byte
    function automatic logic [95:0] kw_word(input int k);
        logic [95:0] w;
        case (k)
            0:       w = 96'("set");
            1:       w = 96'("if");
            2:       w = 96'("else");
            3:       w = 96'("for");
            4:       w = 96'("end");
            5:       w = 96'("render");
            6:       w = 96'("redirect");
            7:       w = 96'({"save_", "session"});
            8:       w = 96'({"add_", "cookie"});
            9:       w = 96'({"set_", "session"});
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [CH_W-1:0] kw_char(input int k, input logic [3:0] i);
        logic [95:0] w;
        int          b;
        w = kw_word(k);
        b = KW_LEN[k] - 1 - int'(i);
        if (b < 0) begin
            return '0;
        end
        return w[8*b +: 8];
    endfunction

    function automatic op_hit_t single_op(input logic [CH_W-1:0] c);
        op_hit_t r;
        r.hit = 1'b1;
        case (c)
            8'h3c:   r.idx = 4'd0;
            8'h3e:   r.idx = 4'd1;
            8'h2b:   r.idx = 4'd2;
            8'h2d:   r.idx = 4'd3;
            8'h2a:   r.idx = 4'd4;
            8'h2f:   r.idx = 4'd5;
            8'h28:   r.idx = 4'd6;
            8'h29:   r.idx = 4'd7;
            8'h5b:   r.idx = 4'd8;
            8'h5d:   r.idx = 4'd9;
            8'h7b:   r.idx = 4'd10;
            8'h7d:   r.idx = 4'd11;
            8'h3a:   r.idx = 4'd12;
            8'h3b:   r.idx = 4'd13;
            8'h2c:   r.idx = 4'd14;
            default:
            begin
                r.hit = 1'b0;
                r.idx = '0;
            end
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/stl_char_if.sv */
// character input channel of the script token lexer
// depends on stl_pkg for payload widths
interface stl_char_if;
    logic                      valid;
    logic                      ready;
    logic [stl_pkg::CH_W-1:0]  ch;
    logic                      has_char;
    logic                      is_last;

    modport source (output valid, output ch, output has_char, output is_last, input ready);
    modport sink (input valid, input ch, input has_char, input is_last, output ready);
endinterface

/* hw/rtl/stl_token_if.sv */
// token output channel of the script token lexer
// depends on stl_pkg for payload widths
interface stl_token_if;
    logic                         valid;
    logic                         ready;
    logic [stl_pkg::KIND_W-1:0]   token_kind;
    logic [stl_pkg::LINE_W-1:0]   token_line;
    logic [stl_pkg::START_W-1:0]  start_offset;
    logic [stl_pkg::LEN_W-1:0]    token_length;
    logic                         last_of_run;

    modport source (output valid, output token_kind, output token_line, output start_offset,
                    output token_length, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input token_line, input start_offset,
                  input token_length, input last_of_run, output ready);
endinterface

/* hw/rtl/script_token_lexer.sv */
// script token lexer: one character per transaction, up to three tokens out per character
// a character's tokens show the cycle after it is accepted, then one per tok.ready cycle
// throughput: one character per cycle while tok.ready is high and each causes at most one
// token; a character causing more tokens holds the input while the result register drains
// reset: rst_n is asynchronous; first_line returns to 1, scan state to the start of a source
// depends on stl_pkg, stl_char_if and stl_token_if
module script_token_lexer #(
    parameter int POSITION_BITS   = stl_pkg::POSITION_BITS_DEF,
    parameter int MAX_KEYWORD_LEN = stl_pkg::MAX_KEYWORD_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    stl_char_if.sink    src,
    stl_token_if.source tok
);

    localparam int POS_W = POSITION_BITS;
    localparam int TL_W  = POSITION_BITS + 1;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_COMMENT = 3'd1;
    localparam logic [2:0] MODE_NUMBER  = 3'd2;
    localparam logic [2:0] MODE_IDENT   = 3'd3;
    localparam logic [2:0] MODE_STRING  = 3'd4;
    localparam logic [2:0] MODE_EQ      = 3'd5;
    localparam logic [2:0] MODE_BANG    = 3'd6;

    localparam logic [stl_pkg::KIND_W-1:0] KIND_NUMBER = 5'd0;
    localparam logic [stl_pkg::KIND_W-1:0] KIND_IDENT  = 5'd1;
    localparam logic [stl_pkg::KIND_W-1:0] KIND_STRING = 5'd2;
    localparam logic [stl_pkg::KIND_W-1:0] KIND_KW0    = 5'd3;
    localparam logic [stl_pkg::KIND_W-1:0] KIND_EQEQ   = 5'd13;
    localparam logic [stl_pkg::KIND_W-1:0] KIND_EQ     = 5'd14;
    localparam logic [stl_pkg::KIND_W-1:0] KIND_NE     = 5'd15;
    localparam logic [stl_pkg::KIND_W-1:0] KIND_OP0    = 5'd16;
    localparam logic [stl_pkg::KIND_W-1:0] KIND_END    = 5'd31;

    localparam logic [0:0] REG_FIRST_LINE = 1'b0;

    localparam logic [stl_pkg::LINE_W-1:0] LINE_TOP = '1;
    localparam logic [POS_W-1:0]           POS_TOP  = '1;
    localparam logic [TL_W-1:0]            TL_TOP   = '1;
    localparam logic [stl_pkg::KW_COUNT-1:0] KW_ALL = '1;

    // scan state
    logic [2:0]                    mode_reg;
    logic                          quote_dbl_reg;
    logic [POS_W-1:0]              pos_reg;
    logic [stl_pkg::LINE_W-1:0]    line_reg;
    logic [POS_W-1:0]              tstart_reg;
    logic [TL_W-1:0]               tlen_reg;
    logic [stl_pkg::KW_COUNT-1:0]  kw_alive_reg;
    logic [stl_pkg::LINE_W-1:0]    first_line_reg;

    logic [2:0]                    mode_next;
    logic                          quote_dbl_next;
    logic [POS_W-1:0]              pos_next;
    logic [stl_pkg::LINE_W-1:0]    line_next;
    logic [POS_W-1:0]              tstart_next;
    logic [TL_W-1:0]               tlen_next;
    logic [stl_pkg::KW_COUNT-1:0]  kw_alive_next;

    // result register, drained one token per cycle while tok.ready is high
    stl_pkg::tok_t res_reg [3];
    stl_pkg::tok_t res_next [3];
    logic [1:0]    cnt_reg;
    logic [1:0]    idx_reg;
    logic [1:0]    n_next;

    logic acc;
    logic out_fire;
    logic rem_one;
    logic cfg_wr;

    function automatic stl_pkg::tok_t mk_tok(
        input logic [stl_pkg::KIND_W-1:0] kind,
        input logic [stl_pkg::LINE_W-1:0] line,
        input logic [POS_W-1:0]           start,
        input logic [stl_pkg::LEN_W-1:0]  len
    );
        stl_pkg::tok_t t;
        t.kind  = kind;
        t.line  = line;
        t.start = stl_pkg::START_W'(33'(start));
        t.len   = len;
        return t;
    endfunction

    function automatic logic [stl_pkg::LEN_W-1:0] len_out(input logic [TL_W-1:0] v);
        return stl_pkg::LEN_W'(33'(v));
    endfunction

    function automatic logic [stl_pkg::KW_COUNT-1:0] kw_kill(
        input logic [stl_pkg::KW_COUNT-1:0] alive,
        input logic [TL_W-1:0]              tl,
        input logic [stl_pkg::CH_W-1:0]     c
    );
        logic [stl_pkg::KW_COUNT-1:0] a;
        a = alive;
        for (int k = 0; k < stl_pkg::KW_COUNT; k++) begin
            if (tl >= TL_W'(stl_pkg::KW_LEN[k]) || tl >= TL_W'(MAX_KEYWORD_LEN)
                || stl_pkg::kw_char(k, tl[3:0]) != c) begin
                a[k] = 1'b0;
            end
        end
        return a;
    endfunction

    function automatic logic [stl_pkg::KIND_W-1:0] ident_kind(
        input logic [stl_pkg::KW_COUNT-1:0] alive,
        input logic [TL_W-1:0]              tl
    );
        logic [stl_pkg::KIND_W-1:0] kind;
        logic                       found;
        kind  = KIND_IDENT;
        found = 1'b0;
        for (int k = 0; k < stl_pkg::KW_COUNT; k++) begin
            if (!found && alive[k] && tl == TL_W'(stl_pkg::KW_LEN[k])) begin
                kind  = KIND_KW0 + stl_pkg::KIND_W'(k);
                found = 1'b1;
            end
        end
        return kind;
    endfunction

    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_FIRST_LINE) ? 32'(first_line_reg) : 32'd0;

    assign rem_one  = (cnt_reg - idx_reg) == 2'd1;
    assign out_fire = tok.valid && tok.ready;
    assign src.ready = (cnt_reg == 2'd0) || (rem_one && tok.ready);
    assign acc      = src.valid && src.ready;

    assign tok.valid        = cnt_reg != 2'd0;
    assign tok.token_kind   = res_reg[idx_reg].kind;
    assign tok.token_line   = res_reg[idx_reg].line;
    assign tok.start_offset = res_reg[idx_reg].start;
    assign tok.token_length = res_reg[idx_reg].len;
    assign tok.last_of_run  = rem_one;

    always_comb
    begin
        logic [stl_pkg::CH_W-1:0] c;
        logic [POS_W-1:0]         p;
        logic                     do_flush;
        logic                     do_idle;
        logic [stl_pkg::CH_W-1:0] quote_ch;
        stl_pkg::op_hit_t         op;

        mode_next      = mode_reg;
        quote_dbl_next = quote_dbl_reg;
        pos_next       = pos_reg;
        line_next      = line_reg;
        tstart_next    = tstart_reg;
        tlen_next      = tlen_reg;
        kw_alive_next  = kw_alive_reg;
        n_next         = 2'd0;
        for (int i = 0; i < 3; i++) begin
            res_next[i] = res_reg[i];
        end

        c        = src.ch;
        p        = pos_reg;
        do_flush = 1'b0;
        do_idle  = 1'b0;
        quote_ch = quote_dbl_reg ? stl_pkg::CH_DQUOTE : stl_pkg::CH_SQUOTE;
        op       = stl_pkg::single_op(c);

        if (src.has_char) begin
            case (mode_reg)
                MODE_COMMENT:
                begin
                    if (c == stl_pkg::CH_LF) begin
                        if (line_next != LINE_TOP) line_next = line_next + 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_NUMBER:
                begin
                    if (stl_pkg::is_digit(c)) begin
                        if (tlen_next != TL_TOP) tlen_next = tlen_next + 1'b1;
                    end else begin
                        do_flush = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                MODE_IDENT:
                begin
                    if (stl_pkg::is_alpha(c) || stl_pkg::is_digit(c)
                        || c == stl_pkg::CH_UNDER || c == stl_pkg::CH_DOT) begin
                        kw_alive_next = kw_kill(kw_alive_next, tlen_next, c);
                        if (tlen_next != TL_TOP) tlen_next = tlen_next + 1'b1;
                    end else begin
                        do_flush = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    if (c == quote_ch) begin
                        res_next[n_next] = mk_tok(KIND_STRING, line_next, tstart_next,
                                                  len_out(tlen_next));
                        n_next    = n_next + 1'b1;
                        mode_next = MODE_IDLE;
                    end else begin
                        if (c == stl_pkg::CH_LF && line_next != LINE_TOP) begin
                            line_next = line_next + 1'b1;
                        end
                        if (tlen_next != TL_TOP) tlen_next = tlen_next + 1'b1;
                    end
                end
                MODE_EQ:
                begin
                    if (c == stl_pkg::CH_EQUAL) begin
                        res_next[n_next] = mk_tok(KIND_EQEQ, line_next, tstart_next, 21'd2);
                        n_next    = n_next + 1'b1;
                        mode_next = MODE_IDLE;
                    end else begin
                        do_flush = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                MODE_BANG:
                begin
                    if (c == stl_pkg::CH_EQUAL) begin
                        res_next[n_next] = mk_tok(KIND_NE, line_next, tstart_next, 21'd2);
                        n_next    = n_next + 1'b1;
                        mode_next = MODE_IDLE;
                    end else begin
                        do_idle = 1'b1;
                    end
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase

            // pending number, identifier or '=' ends on this character
            if (do_flush) begin
                case (mode_reg)
                    MODE_NUMBER:
                    begin
                        res_next[n_next] = mk_tok(KIND_NUMBER, line_next, tstart_next,
                                                  len_out(tlen_next));
                        n_next = n_next + 1'b1;
                    end
                    MODE_IDENT:
                    begin
                        res_next[n_next] = mk_tok(ident_kind(kw_alive_next, tlen_next),
                                                  line_next, tstart_next, len_out(tlen_next));
                        n_next = n_next + 1'b1;
                    end
                    MODE_EQ:
                    begin
                        res_next[n_next] = mk_tok(KIND_EQ, line_next, tstart_next, 21'd1);
                        n_next = n_next + 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (do_idle) begin
                mode_next = MODE_IDLE;
                if (stl_pkg::is_space(c)) begin
                    if (c == stl_pkg::CH_LF && line_next != LINE_TOP) begin
                        line_next = line_next + 1'b1;
                    end
                end else if (c == stl_pkg::CH_HASH) begin
                    mode_next = MODE_COMMENT;
                end else if (stl_pkg::is_digit(c)) begin
                    mode_next   = MODE_NUMBER;
                    tstart_next = p;
                    tlen_next   = TL_W'(1);
                end else if (stl_pkg::is_alpha(c) || c == stl_pkg::CH_UNDER) begin
                    mode_next     = MODE_IDENT;
                    tstart_next   = p;
                    kw_alive_next = kw_kill(KW_ALL, '0, c);
                    tlen_next     = TL_W'(1);
                end else if (c == stl_pkg::CH_DQUOTE || c == stl_pkg::CH_SQUOTE) begin
                    mode_next      = MODE_STRING;
                    quote_dbl_next = (c == stl_pkg::CH_DQUOTE);
                    tstart_next    = (p != POS_TOP) ? p + 1'b1 : POS_TOP;
                    tlen_next      = '0;
                end else if (c == stl_pkg::CH_EQUAL) begin
                    mode_next   = MODE_EQ;
                    tstart_next = p;
                end else if (c == stl_pkg::CH_BANG) begin
                    mode_next   = MODE_BANG;
                    tstart_next = p;
                end else if (op.hit) begin
                    res_next[n_next] = mk_tok(KIND_OP0 + stl_pkg::KIND_W'(op.idx), line_next,
                                              p, 21'd1);
                    n_next = n_next + 1'b1;
                end
            end

            pos_next = (p != POS_TOP) ? p + 1'b1 : POS_TOP;
        end

        if (src.is_last) begin
            case (mode_next)
                MODE_NUMBER:
                begin
                    res_next[n_next] = mk_tok(KIND_NUMBER, line_next, tstart_next,
                                              len_out(tlen_next));
                    n_next = n_next + 1'b1;
                end
                MODE_IDENT:
                begin
                    res_next[n_next] = mk_tok(ident_kind(kw_alive_next, tlen_next),
                                              line_next, tstart_next, len_out(tlen_next));
                    n_next = n_next + 1'b1;
                end
                MODE_STRING:
                begin
                    // unterminated string keeps the text seen so far
                    res_next[n_next] = mk_tok(KIND_STRING, line_next, tstart_next,
                                              len_out(tlen_next));
                    n_next = n_next + 1'b1;
                end
                MODE_EQ:
                begin
                    res_next[n_next] = mk_tok(KIND_EQ, line_next, tstart_next, 21'd1);
                    n_next = n_next + 1'b1;
                end
                default:
                begin
                end
            endcase
            res_next[n_next] = mk_tok(KIND_END, line_next, pos_next, '0);
            n_next = n_next + 1'b1;

            mode_next      = MODE_IDLE;
            quote_dbl_next = 1'b0;
            pos_next       = '0;
            line_next      = first_line_reg;
            tstart_next    = '0;
            tlen_next      = '0;
            kw_alive_next  = KW_ALL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= MODE_IDLE;
            quote_dbl_reg  <= 1'b0;
            pos_reg        <= '0;
            line_reg       <= stl_pkg::FIRST_LINE_RESET;
            tstart_reg     <= '0;
            tlen_reg       <= '0;
            kw_alive_reg   <= KW_ALL;
            first_line_reg <= stl_pkg::FIRST_LINE_RESET;
        end else begin
            if (acc) begin
                mode_reg      <= mode_next;
                quote_dbl_reg <= quote_dbl_next;
                pos_reg       <= pos_next;
                line_reg      <= line_next;
                tstart_reg    <= tstart_next;
                tlen_reg      <= tlen_next;
                kw_alive_reg  <= kw_alive_next;
            end
            if (cfg_wr && paddr[2] == REG_FIRST_LINE) begin
                first_line_reg <= pwdata[stl_pkg::LINE_W-1:0];
                // before the first character the running line count follows the register
                if (!acc && pos_reg == '0) begin
                    line_reg <= pwdata[stl_pkg::LINE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else if (acc && n_next != 2'd0) begin
            cnt_reg <= n_next;
            idx_reg <= 2'd0;
        end else if (out_fire) begin
            if (rem_one) begin
                cnt_reg <= 2'd0;
                idx_reg <= 2'd0;
            end else begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && n_next != 2'd0) begin
            for (int i = 0; i < 3; i++) begin
                res_reg[i] <= res_next[i];
            end
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        tok.valid |-> (idx_reg < cnt_reg) && (cnt_reg != 2'd3 || idx_reg != 2'd3))
        else $error("result index beyond filled entries");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        acc && src.is_last |=> pos_reg == '0 && mode_reg == MODE_IDLE && tlen_reg == '0)
        else $error("end of source did not restart the scan state");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        acc && src.is_last |=> tok.valid && res_reg[cnt_reg - 2'd1].kind == KIND_END)
        else $error("end token is not the final result of its character");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        acc |-> cnt_reg == 2'd0 || (rem_one && out_fire))
        else $error("character accepted while results are still pending");

endmodule

/* sim/script_token_lexer_checker.sv */
// token checker for the script token lexer: watches the character, token and register ports,
// works out the expected tokens of every accepted character and compares them in order
// depends on stl_pkg, stl_char_if and stl_token_if
module script_token_lexer_checker #(
    parameter logic [2:0] FIRST_LINE_ADDR = 3'd0
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    stl_char_if         chars,
    stl_token_if        tokens,
    output int          fail_count,
    output int          pending_tokens
);

    localparam int POS_W      = stl_pkg::POSITION_BITS_DEF;
    localparam int MAX_KW_LEN = stl_pkg::MAX_KEYWORD_LEN_DEF;

    localparam logic [POS_W:0] LEN_ONE = 1;
    localparam logic [POS_W:0] LEN_TWO = 2;

    localparam logic [4:0] KIND_NUMBER   = 5'd0;
    localparam logic [4:0] KIND_IDENT    = 5'd1;
    localparam logic [4:0] KIND_STRING   = 5'd2;
    localparam logic [4:0] KIND_KEYWORD0 = 5'd3;
    localparam logic [4:0] KIND_EQ_EQ    = 5'd13;
    localparam logic [4:0] KIND_ASSIGN   = 5'd14;
    localparam logic [4:0] KIND_NOT_EQ   = 5'd15;
    localparam logic [4:0] KIND_OP0      = 5'd16;
    localparam logic [4:0] KIND_END      = 5'd31;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_COMMENT,
        SCAN_NUMBER,
        SCAN_WORD,
        SCAN_QUOTED,
        SCAN_EQ,
        SCAN_BANG
    } scan_mode_t;

    typedef struct packed {
        stl_pkg::tok_t tok;
        logic          last;
    } token_rec_t;

    string kw_names [10] = '{"set", "if", "else", "for", "end", "render", "redirect",
                             string'({"save_", "session"}), string'({"add_", "cookie"}),
                             string'({"set_", "session"})};
    string op_chars = "<>+-*/()[]{}:;,";

    scan_mode_t       mode;
    logic             dq;
    logic [POS_W-1:0] pos;
    logic [19:0]      line_no;
    logic [19:0]      first_line;
    logic [POS_W-1:0] text_start;
    logic [POS_W:0]   text_len;
    logic [7:0]       word_text [MAX_KW_LEN];
    token_rec_t       held;
    bit               have_held;
    token_rec_t       due_tokens[$];
    int               mismatches = 0;
    int               pending_n = 0;

    assign fail_count     = mismatches;
    assign pending_tokens = pending_n;

    function automatic bit is_numeral(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
        return (p == '1) ? p : p + 1'b1;
    endfunction

    function automatic logic [4:0] word_kind();
        bit hit;
        for (int k = 0; k < 10; k++) begin
            if (text_len == kw_names[k].len()) begin
                hit = 1'b1;
                for (int i = 0; i < kw_names[k].len(); i++) begin
                    if (word_text[i] != kw_names[k][i]) hit = 1'b0;
                end
                if (hit) return KIND_KEYWORD0 + 5'(k);
            end
        end
        return KIND_IDENT;
    endfunction

    function automatic bit field_ok(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: token %s expected %0d actual %0d", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // tokens of one character are held back one step so the last one can be marked
    task automatic add_token(input logic [4:0] kind, input logic [POS_W-1:0] start,
                             input logic [POS_W:0] len);
        token_rec_t r;
        if (have_held) due_tokens = {due_tokens, held};
        r.tok.kind  = kind;
        r.tok.line  = line_no;
        r.tok.start = start;
        r.tok.len   = len;
        r.last      = 1'b0;
        held        = r;
        have_held   = 1'b1;
    endtask

    task automatic bump_line();
        if (line_no != '1) line_no = line_no + 1'b1;
    endtask

    task automatic bump_len();
        if (text_len != '1) text_len = text_len + 1'b1;
    endtask

    task automatic start_source();
        mode       = SCAN_IDLE;
        dq         = 1'b0;
        pos        = '0;
        line_no    = first_line;
        text_start = '0;
        text_len   = '0;
    endtask

    task automatic close_token();
        case (mode)
            SCAN_NUMBER: add_token(KIND_NUMBER, text_start, text_len);
            SCAN_WORD:   add_token(word_kind(), text_start, text_len);
            SCAN_QUOTED: add_token(KIND_STRING, text_start, text_len);
            SCAN_EQ:     add_token(KIND_ASSIGN, text_start, LEN_ONE);
            default:     ;
        endcase
        mode = SCAN_IDLE;
    endtask

    task automatic begin_char(input logic [7:0] c, input logic [POS_W-1:0] p);
        mode = SCAN_IDLE;
        if (is_blank(c)) begin
            if (c == stl_pkg::CH_LF) bump_line();
        end else if (c == stl_pkg::CH_HASH) begin
            mode = SCAN_COMMENT;
        end else if (is_numeral(c)) begin
            mode       = SCAN_NUMBER;
            text_start = p;
            text_len   = LEN_ONE;
        end else if (is_letter(c) || c == stl_pkg::CH_UNDER) begin
            mode         = SCAN_WORD;
            text_start   = p;
            word_text[0] = c;
            text_len     = LEN_ONE;
        end else if (c == stl_pkg::CH_DQUOTE || c == stl_pkg::CH_SQUOTE) begin
            mode       = SCAN_QUOTED;
            dq         = (c == stl_pkg::CH_DQUOTE);
            text_start = next_pos(p);
            text_len   = '0;
        end else if (c == stl_pkg::CH_EQUAL) begin
            mode       = SCAN_EQ;
            text_start = p;
        end else if (c == stl_pkg::CH_BANG) begin
            mode       = SCAN_BANG;
            text_start = p;
        end else begin
            // anything not in the operator set is dropped
            for (int k = 0; k < op_chars.len(); k++) begin
                if (op_chars[k] == c) add_token(KIND_OP0 + 5'(k), p, LEN_ONE);
            end
        end
    endtask

    task automatic lex_char(input logic [7:0] c, input logic has, input logic last);
        logic [POS_W-1:0] p;
        if (has) begin
            p = pos;
            case (mode)
                SCAN_COMMENT:
                begin
                    if (c == stl_pkg::CH_LF) begin
                        bump_line();
                        mode = SCAN_IDLE;
                    end
                end
                SCAN_NUMBER:
                begin
                    if (is_numeral(c)) begin
                        bump_len();
                    end else begin
                        close_token();
                        begin_char(c, p);
                    end
                end
                SCAN_WORD:
                begin
                    if (is_letter(c) || is_numeral(c) || c == stl_pkg::CH_UNDER ||
                        c == stl_pkg::CH_DOT) begin
                        if (text_len < MAX_KW_LEN) word_text[text_len] = c;
                        bump_len();
                    end else begin
                        close_token();
                        begin_char(c, p);
                    end
                end
                SCAN_QUOTED:
                begin
                    if (c == (dq ? stl_pkg::CH_DQUOTE : stl_pkg::CH_SQUOTE)) begin
                        add_token(KIND_STRING, text_start, text_len);
                        mode = SCAN_IDLE;
                    end else begin
                        if (c == stl_pkg::CH_LF) bump_line();
                        bump_len();
                    end
                end
                SCAN_EQ:
                begin
                    if (c == stl_pkg::CH_EQUAL) begin
                        add_token(KIND_EQ_EQ, text_start, LEN_TWO);
                        mode = SCAN_IDLE;
                    end else begin
                        close_token();
                        begin_char(c, p);
                    end
                end
                SCAN_BANG:
                begin
                    if (c == stl_pkg::CH_EQUAL) begin
                        add_token(KIND_NOT_EQ, text_start, LEN_TWO);
                        mode = SCAN_IDLE;
                    end else begin
                        begin_char(c, p);
                    end
                end
                default: begin_char(c, p);
            endcase
            pos = next_pos(p);
        end
        if (last) begin
            close_token();
            add_token(KIND_END, pos, '0);
            start_source();
        end
        if (have_held) begin
            held.last = 1'b1;
            due_tokens = {due_tokens, held};
            have_held = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : monitor
        token_rec_t want;
        bit         ok;
        if (!rst_n) begin
            first_line = stl_pkg::FIRST_LINE_RESET;
            start_source();
            have_held = 1'b0;
            due_tokens.delete();
        end else begin
            if (tokens.valid && tokens.ready) begin
                if (due_tokens.size() == 0) begin
                    $display("%0t: token expected none actual kind %0d line %0d start %0d len %0d",
                             $time, tokens.token_kind, tokens.token_line,
                             tokens.start_offset, tokens.token_length);
                    mismatches++;
                end else begin
                    want = due_tokens.pop_front();
                    ok = field_ok("kind", want.tok.kind, tokens.token_kind);
                    ok = field_ok("line", want.tok.line, tokens.token_line) && ok;
                    ok = field_ok("start", want.tok.start, tokens.start_offset) && ok;
                    ok = field_ok("length", want.tok.len, tokens.token_length) && ok;
                    ok = field_ok("last_of_run", want.last, tokens.last_of_run) && ok;
                    if (!ok) mismatches++;
                end
            end
            if (psel && penable && pwrite && pready && paddr == FIRST_LINE_ADDR) begin
                first_line = pwdata[19:0];
                // only reloads the line count before the first character of a source
                if (pos == '0) line_no = first_line;
            end
            if (chars.valid && chars.ready) begin
                lex_char(chars.ch, chars.has_char, chars.is_last);
            end
        end
        pending_n = due_tokens.size();
    end

endmodule

/* sim/script_token_lexer_test.sv */
// testbench top for the script token lexer: clock, reset, register writes, character
// stimulus and token back-pressure; the checker beside the block decides on the tokens
// depends on stl_pkg, stl_char_if, stl_token_if, script_token_lexer and its checker
module script_token_lexer_test;

    localparam logic [2:0] ADDR_FIRST_LINE  = 3'd0;
    localparam int         QUIET_LIMIT      = 2000;
    localparam int         SETTLE_CYCLES    = 8;
    localparam int         LONG_HOLD_CYCLES = 80;
    localparam int         PHASE_ITEMS      = 60;
    localparam int         PHASES           = 5;

    // how a piece of source text is closed
    localparam int END_OPEN     = 0;
    localparam int END_ON_CHAR  = 1;
    localparam int END_SEPARATE = 2;
    localparam int END_ANY      = 3;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_tokens;
    int          quiet_cycles = 0;
    int          burst_left = 0;
    int          items_sent = 0;
    bit          long_hold_req = 1'b0;
    logic [7:0]  src_text[$];

    string kw_list [10] = '{"set", "if", "else", "for", "end", "render", "redirect",
                            string'({"save_", "session"}), string'({"add_", "cookie"}),
                            string'({"set_", "session"})};
    string op_list [19] = '{"==", "=", "!=", "!", "<", ">", "+", "-", "*", "/", "(", ")",
                            "[", "]", "{", "}", ":", ";", ","};

    stl_char_if  char_ch ();
    stl_token_if tok_ch ();

    script_token_lexer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .src     (char_ch),
        .tok     (tok_ch)
    );

    script_token_lexer_checker #(
        .FIRST_LINE_ADDR (ADDR_FIRST_LINE)
    ) token_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .chars          (char_ch),
        .tokens         (tok_ch),
        .fail_count     (fail_count),
        .pending_tokens (pending_tokens)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // token side: stall patterns picked at random for random stretches, plus one long hold-off
    initial
    begin : receiver
        int style;
        int style_left;
        style        = 0;
        style_left   = 0;
        tok_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                tok_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
            end
            if (style_left == 0) begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(10, 60);
            end
            style_left--;
            case (style)
                0:       tok_ch.ready <= 1'b1;
                1:       tok_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       tok_ch.ready <= ($urandom_range(0, 3) == 0);
                default: tok_ch.ready <= (style_left % 3 == 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if ((char_ch.valid && char_ch.ready) || (tok_ch.valid && tok_ch.ready) ||
            (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("script_token_lexer_test: FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        return $urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 4);
    endfunction

    function automatic logic [7:0] word_char(input bit lead);
        int r;
        r = $urandom_range(0, lead ? 52 : 64);
        if (r < 26) return 8'h61 + 8'(r);
        if (r < 52) return 8'h41 + 8'(r - 26);
        if (r == 52 || r == 64) return stl_pkg::CH_UNDER;
        if (r == 63) return stl_pkg::CH_DOT;
        return 8'h30 + 8'(r - 53);
    endfunction

    // one character transaction; valid stays high across a burst
    task automatic send_item(input logic [7:0] c, input logic has, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = pick_gap();
            if (gap > 0) begin
                char_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        char_ch.ch       <= c;
        char_ch.has_char <= has;
        char_ch.is_last  <= last;
        char_ch.valid    <= 1'b1;
        do @(posedge clk); while (!char_ch.ready);
        @(negedge clk);
        burst_left--;
        if (has || last) items_sent++;
    endtask

    task automatic send_text(input int end_style);
        bit on_char;
        int n;
        n = src_text.size();
        on_char = (n > 0) && (end_style == END_ON_CHAR ||
                              (end_style == END_ANY && $urandom_range(0, 1) == 1));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 39) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(src_text[i], 1'b1, on_char && i == n - 1);
        end
        if (end_style != END_OPEN && !on_char) send_item(8'($urandom), 1'b0, 1'b1);
        src_text.delete();
    endtask

    task automatic pause_until_drained();
        char_ch.valid <= 1'b0;
        while (pending_tokens != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        burst_left = 0;
    endtask

    task automatic write_first_line(input logic [19:0] value);
        logic [11:0] junk;
        junk = 12'($urandom);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FIRST_LINE;
        pwdata  <= {junk, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic put_char(input logic [7:0] c);
        src_text = {src_text, c};
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
    endtask

    task automatic add_separator();
        int n;
        int r;
        n = $urandom_range(0, 2);
        repeat (n)
        begin
            r = $urandom_range(0, 8);
            case (r)
                3:       put_char(8'h09);
                4, 5:    put_char(stl_pkg::CH_LF);
                6:       put_char(8'h0d);
                7:       put_char(8'h0b);
                8:       put_char(8'h0c);
                default: put_char(8'h20);
            endcase
        end
    endtask

    // mostly well-formed lexemes with random content, some near-miss keywords and noise
    task automatic add_lexeme();
        int         pick;
        int         n;
        string      kw;
        logic [7:0] quote;
        logic [7:0] c;
        pick = $urandom_range(0, 19);
        case (pick)
            0, 1, 2, 3: add_text(kw_list[$urandom_range(0, 9)]);
            4:
            begin
                kw = kw_list[$urandom_range(0, 9)];
                n  = $urandom_range(1, kw.len());
                add_text(kw.substr(0, n - 1));
                if ($urandom_range(0, 1) == 1) put_char(word_char(1'b0));
            end
            5, 6:
            begin
                put_char(word_char(1'b1));
                n = $urandom_range(0, 13);
                repeat (n) put_char(word_char(1'b0));
            end
            7, 8:
            begin
                n = $urandom_range(1, 7);
                repeat (n) put_char(8'h30 + 8'($urandom_range(0, 9)));
            end
            9, 10:
            begin
                quote = ($urandom_range(0, 1) == 1) ? stl_pkg::CH_DQUOTE : stl_pkg::CH_SQUOTE;
                put_char(quote);
                n = $urandom_range(0, 10);
                repeat (n)
                begin
                    c = 8'h20 + 8'($urandom_range(0, 94));
                    if ($urandom_range(0, 7) == 0) c = stl_pkg::CH_LF;
                    if ($urandom_range(0, 15) == 0) c = 8'($urandom);
                    put_char(c);
                end
                if ($urandom_range(0, 9) != 0) put_char(quote);
            end
            11, 12, 13, 14: add_text(op_list[$urandom_range(0, 18)]);
            15:
            begin
                put_char(stl_pkg::CH_HASH);
                n = $urandom_range(0, 8);
                repeat (n) put_char(8'($urandom));
                put_char(stl_pkg::CH_LF);
            end
            16: put_char(8'($urandom));
            default: ;
        endcase
        add_separator();
    endtask

    initial
    begin : stimulus
        int          phase_start;
        int          n;
        logic [19:0] line_value;
        rst_n            = 1'b0;
        char_ch.valid    = 1'b0;
        char_ch.ch       = '0;
        char_ch.has_char = 1'b0;
        char_ch.is_last  = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // keyword, number, '==', string across a line, '!=', lone bang, dropped bytes,
        // '=' then identifier ended by a newline, comment, unterminated string at the end
        add_text("if 7==\"a\nb\"!=!@");
        put_char(8'hff);
        add_text("=x\n#c\n'q");
        put_char(8'h00);
        send_text(END_ON_CHAR);
        send_item(8'h5a, 1'b0, 1'b1);
        send_item(8'ha5, 1'b0, 1'b0);
        pause_until_drained();

        // line count saturates, and a pending '=' is closed by the end of the source
        write_first_line(20'hffffe);
        add_text("\n\nv=");
        send_text(END_ON_CHAR);
        pause_until_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       line_value = 20'h00000;
                1:       line_value = 20'hfffff;
                4:       line_value = 20'h00001;
                default: line_value = 20'($urandom);
            endcase
            write_first_line(line_value);
            if (phase == 1) long_hold_req = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                n = $urandom_range(2, 18);
                repeat (n) add_lexeme();
                send_text(END_ANY);
            end
            // odd phases leave a source open so the next register write lands mid-source
            if (phase % 2 == 1) begin
                n = $urandom_range(1, 6);
                repeat (n) add_lexeme();
                send_text(END_OPEN);
            end
            pause_until_drained();
        end

        if (fail_count == 0) begin
            $display("script_token_lexer_test: PASS");
        end else begin
            $display("script_token_lexer_test: FAIL");
        end
        $finish;
    end

endmodule
